[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the k-way merge block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KWM_ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define KWM_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/kwm_pkg.sv]
// Package of the k-way sorted merge: defaults, command codes, sequencer
// states and the control bundle of the shared compare unit. No dependencies.
package kwm_pkg;

    localparam int NUM_LISTS_DEF   = 8;
    localparam int LIST_DEPTH_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int IN_VALUE_W  = 32;
    localparam int IN_LIST_W   = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_MERGE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_EMPTY
    } kwm_state_t;

    typedef struct packed {
        logic clear;
        logic cand_valid;
    } kwm_cmp_ctrl_t;

endpackage

[rtl/kwm_min_unit.sv]
// Shared compare unit of the merge: keeps the smallest signed head seen
// during one scan and the list it came from. Depends on kwm_pkg.
module kwm_min_unit #(
    parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF,
    parameter int LIST_W      = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kwm_pkg::kwm_cmp_ctrl_t    ctrl,
    input  logic [VALUE_WIDTH-1:0]    cand_value,
    input  logic [LIST_W-1:0]         cand_list,
    output logic [VALUE_WIDTH-1:0]    best_value,
    output logic [LIST_W-1:0]         best_list,
    output logic                      best_found
);
    import kwm_pkg::*;

    logic                   found_reg;
    logic                   found_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [LIST_W-1:0]      list_reg;
    logic [LIST_W-1:0]      list_next;
    logic                   take;

    // strict less keeps the lowest list index on equal heads
    assign take = ctrl.cand_valid &&
                  (!found_reg || ($signed(cand_value) < $signed(value_reg)));

    always_comb
    begin
        found_next = found_reg;
        value_next = value_reg;
        list_next  = list_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
            value_next = cand_value;
            list_next  = cand_list;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        list_reg  <= list_next;
    end

    assign best_value = value_reg;
    assign best_list  = list_reg;
    assign best_found = found_reg;

endmodule

[rtl/k_way_sorted_merge.sv]
// Channel   | Dir | Accepted when      | Contents
// s_axis    | in  | s_tvalid&s_tready  | tuser: cmd; tdata: list_index, value
// m_axis    | out | m_tvalid&m_tready  | tdata: value_res; tlast: is_last;
//           |     |                    | tuser: empty_set, overflow
// For each stored element a merge does one element store read per list
// head through the shared compare unit, one drain and one emit. With nothing
// stored it emits one empty result. An output stall holds the merge.
// rst_n clears counts, read positions and the overflow flag; the element
// store itself is not cleared. s_tready is low while a merge runs.
// Top level of the k-way sorted merge: element store, counts, sequencer and
// output register. Depends on kwm_pkg, kwm_min_unit and assert_macros.svh.
`include "assert_macros.svh"

module k_way_sorted_merge #(
    parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kwm_pkg::IN_TDATA_W-1:0]    s_tdata,  // list_index[2:0], value[34:3], zero pad
    input  logic                              s_tuser,  // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kwm_pkg::OUT_TDATA_W-1:0]   m_tdata,  // value_res[31:0]
    output logic                              m_tlast,
    output logic [1:0]                        m_tuser   // empty_set[0], overflow[1]
);
    import kwm_pkg::*;

    localparam int SLOTS  = NUM_LISTS * LIST_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int LW     = $clog2(NUM_LISTS);
    localparam int CW     = $clog2(LIST_DEPTH + 1);
    localparam int TW     = $clog2(SLOTS + 1);

    kwm_state_t state_reg, state_next;

    logic [CW-1:0]     cnt_reg [NUM_LISTS];
    logic [CW-1:0]     cnt_next [NUM_LISTS];
    logic [CW-1:0]     pos_reg [NUM_LISTS];
    logic [CW-1:0]     pos_next [NUM_LISTS];
    logic [TW-1:0]     total_reg, total_next;
    logic [TW-1:0]     emitted_reg, emitted_next;
    logic              dropped_reg, dropped_next;
    logic [LW-1:0]     scan_reg, scan_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [LW-1:0]     rd_list_reg;

    logic [VALUE_WIDTH-1:0] store_mem [SLOTS];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [VALUE_WIDTH-1:0] wr_value;
    logic [ADDR_W-1:0]      mem_addr;
    logic                   mem_we;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_empty_reg, m_empty_next;
    logic                   m_ovf_reg, m_ovf_next;

    logic                   in_fire;
    logic                   in_cmd;
    logic [IN_LIST_W-1:0]   in_list;
    logic                   in_list_ok;
    logic [LW-1:0]          sel;
    logic [CW-1:0]          offs;
    logic                   out_free;
    logic                   emit_last;
    logic                   merge_done;

    kwm_cmp_ctrl_t          cmp_ctrl;
    logic [VALUE_WIDTH-1:0] best_value;
    logic [LW-1:0]          best_list;
    logic                   best_found;

    assign in_cmd     = s_tuser;
    assign in_list    = s_tdata[IN_LIST_W-1:0];
    assign wr_value   = VALUE_WIDTH'(s_tdata[IN_LIST_W +: IN_VALUE_W]);
    assign in_list_ok = (32'(in_list) < NUM_LISTS);
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign emit_last  = ((emitted_reg + TW'(1)) == total_reg);
    assign merge_done = (state_reg == ST_EMIT) && out_free && emit_last;

    // one list selection feeds counts, cursors and the store address
    assign sel  = (state_reg == ST_IDLE) ? LW'(in_list) : scan_reg;
    assign offs = (state_reg == ST_IDLE) ? cnt_reg[sel] : pos_reg[sel];
    assign mem_addr = ADDR_W'(ADDR_W'(sel) * ADDR_W'(LIST_DEPTH)) + ADDR_W'(offs);
    assign mem_we   = in_fire && (in_cmd == CMD_APPEND) && in_list_ok &&
                      (cnt_reg[sel] < CW'(LIST_DEPTH));

    assign cmp_ctrl.clear      = (state_reg == ST_SCAN) && (scan_reg == '0);
    assign cmp_ctrl.cand_valid = rd_valid_reg;

    kwm_min_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .LIST_W      (LW)
    ) u_min (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cmp_ctrl),
        .cand_value (rd_data_reg),
        .cand_list  (rd_list_reg),
        .best_value (best_value),
        .best_list  (best_list),
        .best_found (best_found)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        emitted_next  = emitted_reg;
        dropped_next  = dropped_reg;
        scan_next     = scan_reg;
        rd_valid_next = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_empty_next  = m_empty_reg;
        m_ovf_next    = m_ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == CMD_MERGE)
                    begin
                        scan_next  = '0;
                        state_next = (total_reg == '0) ? ST_EMPTY : ST_SCAN;
                    end
                    else if (in_list_ok)
                    begin
                        if (mem_we)
                        begin
                            cnt_next[sel] = cnt_reg[sel] + CW'(1);
                            total_next    = total_reg + TW'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                rd_valid_next = (pos_reg[sel] < cnt_reg[sel]);
                if (scan_reg == LW'(NUM_LISTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + LW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = OUT_TDATA_W'(best_value);
                    m_last_next   = emit_last;
                    m_empty_next  = 1'b0;
                    m_ovf_next    = dropped_reg;
                    scan_next     = '0;
                    if (emit_last)
                    begin
                        for (int i = 0; i < NUM_LISTS; i++)
                        begin
                            cnt_next[i] = '0;
                            pos_next[i] = '0;
                        end
                        total_next   = '0;
                        emitted_next = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        pos_next[best_list] = pos_reg[best_list] + CW'(1);
                        emitted_next        = emitted_reg + TW'(1);
                        state_next          = ST_SCAN;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = '0;
                    m_last_next   = 1'b1;
                    m_empty_next  = 1'b1;
                    m_ovf_next    = dropped_reg;
                    dropped_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                cnt_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            total_reg    <= '0;
            emitted_reg  <= '0;
            dropped_reg  <= 1'b0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pos_reg      <= pos_next;
            total_reg    <= total_next;
            emitted_reg  <= emitted_next;
            dropped_reg  <= dropped_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // element store: one shared address for append writes and head reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= wr_value;
        end
        rd_data_reg <= store_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        rd_list_reg <= sel;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_empty_reg <= m_empty_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_empty_reg;
    assign m_tuser[1] = m_ovf_reg;

    `KWM_ASSERT_NEVER(a_emit_bound, emitted_reg > total_reg, "more results than stored values")
    `KWM_ASSERT_NEVER(a_emit_found, (state_reg == ST_EMIT) && !best_found, "emit without a head")
    `KWM_ASSERT_CLK(a_last_clears, merge_done |=> (total_reg == '0), "state not cleared")

endmodule

[test/k_way_sorted_merge_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for k_way_sorted_merge: append and merge requests with random
// stalls on both streams, results checked against a built-in list model.
// Depends on kwm_pkg and the k_way_sorted_merge RTL.

module k_way_sorted_merge_test;

    import kwm_pkg::*;

    localparam int NUM_LISTS    = NUM_LISTS_DEF;
    localparam int LIST_DEPTH   = LIST_DEPTH_DEF;
    localparam int PAD_W        = IN_TDATA_W - IN_VALUE_W - IN_LIST_W;
    localparam int DRAIN_CYCLES = 2 * (NUM_LISTS + 2);
    localparam logic [31:0] VALUE_MAX = 32'h7fff_ffff;
    localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        empty;
        logic        ovf;
    } merge_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;   // list_index[2:0], value[34:3], zero pad
    logic                    s_tuser = 1'b0; // cmd
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;        // value_res[31:0]
    logic                    m_tlast;
    logic [1:0]              m_tuser;        // empty_set[0], overflow[1]

    // list model
    logic signed [31:0] list_store [NUM_LISTS][LIST_DEPTH];
    int                 list_fill [NUM_LISTS];
    bit                 dropped = 1'b0;
    merge_result_t      merged_due [$];

    int error_count = 0;
    int items_sent  = 0;
    bit sender_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    int stall_left  = 0;

    k_way_sorted_merge i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void predict_append(input logic [2:0] lst, input logic [31:0] value);
        if (list_fill[lst] < LIST_DEPTH)
        begin
            list_store[lst][list_fill[lst]] = value;
            list_fill[lst]++;
        end
        else
            dropped = 1'b1;
    endfunction

    // Pick the smallest head each step; ties go to the lowest list.
    function automatic void predict_merge();
        int                 pos [NUM_LISTS];
        int                 total;
        int                 best;
        logic signed [31:0] best_val;
        merge_result_t      res;
        total = 0;
        for (int l = 0; l < NUM_LISTS; l++)
        begin
            pos[l] = 0;
            total += list_fill[l];
        end
        res.ovf = dropped;
        if (total == 0)
        begin
            res.value = '0;
            res.last  = 1'b1;
            res.empty = 1'b1;
            merged_due = {merged_due, res};
        end
        for (int n = 0; n < total; n++)
        begin
            best = -1;
            best_val = '0;
            for (int l = 0; l < NUM_LISTS; l++)
            begin
                if (pos[l] < list_fill[l] && (best < 0 || list_store[l][pos[l]] < best_val))
                begin
                    best = l;
                    best_val = list_store[l][pos[l]];
                end
            end
            pos[best]++;
            res.value = best_val;
            res.last  = (n == total - 1);
            res.empty = 1'b0;
            merged_due = {merged_due, res};
        end
        for (int l = 0; l < NUM_LISTS; l++)
            list_fill[l] = 0;
        dropped = 1'b0;
    endfunction

    task automatic send_request(input logic cmd, input logic [2:0] lst,
                                input logic [31:0] value);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, value, lst};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (cmd == CMD_MERGE)
            predict_merge();
        else
            predict_append(lst, value);
    endtask

    task automatic send_merge();
        send_request(CMD_MERGE, 3'($urandom), $urandom);
    endtask

    // Fill lists in random interleaving, then merge. In order, each list is non-decreasing.
    task automatic load_and_merge(input int max_fill, input bit all_lists,
                                  input bit in_order, input bit narrow);
        int     fill_left [NUM_LISTS];
        longint tail [NUM_LISTS];
        int     remaining;
        int     l;
        longint step;
        logic [31:0] value;
        remaining = 0;
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            fill_left[i] = (all_lists || $urandom_range(0, 1) == 1) ?
                           $urandom_range(all_lists ? max_fill : 1, max_fill) : 0;
            remaining += fill_left[i];
            if (narrow)
                tail[i] = -4;
            else
                tail[i] = longint'($signed($urandom));
        end
        while (remaining > 0)
        begin
            l = $urandom_range(0, NUM_LISTS - 1);
            if (fill_left[l] == 0)
                continue;
            if (!in_order)
                value = $urandom;
            else
            begin
                value = tail[l][31:0];
                if (narrow)
                    step = $urandom_range(0, 1);
                else
                    step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 28);
                // saturate at the largest value so ordering holds
                tail[l] = (tail[l] + step > longint'(2147483647)) ?
                          longint'(2147483647) : tail[l] + step;
            end
            send_request(CMD_APPEND, 3'(l), value);
            fill_left[l]--;
            remaining--;
        end
        send_merge();
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (sink_stalls && $urandom_range(0, 7) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        merge_result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (merged_due.size() == 0)
            begin
                $error("unexpected result: value_res %0d", $signed(m_tdata));
                error_count++;
            end
            else
            begin
                due = merged_due.pop_front();
                if (m_tdata !== due.value)
                begin
                    $error("value_res: expected %0d, actual %0d",
                           $signed(due.value), $signed(m_tdata));
                    error_count++;
                end
                if (m_tlast !== due.last)
                begin
                    $error("is_last: expected %0b, actual %0b", due.last, m_tlast);
                    error_count++;
                end
                if (m_tuser[0] !== due.empty)
                begin
                    $error("empty_set: expected %0b, actual %0b", due.empty, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== due.ovf)
                begin
                    $error("overflow: expected %0b, actual %0b", due.ovf, m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_merge();
        send_merge();
    endtask

    task automatic test_extreme_values();
        send_request(CMD_APPEND, 3'd0, VALUE_MIN);
        send_request(CMD_APPEND, 3'd7, VALUE_MIN);
        send_request(CMD_APPEND, 3'd3, 32'd0);
        send_request(CMD_APPEND, 3'd0, 32'hffff_ffff);
        send_request(CMD_APPEND, 3'd3, VALUE_MAX);
        send_request(CMD_APPEND, 3'd7, VALUE_MAX);
        send_merge();
    endtask

    task automatic test_equal_heads();
        send_request(CMD_APPEND, 3'd2, 32'd5);
        send_request(CMD_APPEND, 3'd1, 32'd5);
        send_request(CMD_APPEND, 3'd6, 32'd5);
        send_request(CMD_APPEND, 3'd2, 32'd5);
        send_request(CMD_APPEND, 3'd6, 32'd6);
        send_merge();
    endtask

    // Ninth append to one list is dropped and raises the sticky flag.
    task automatic test_list_overflow();
        for (int i = 1; i <= LIST_DEPTH + 1; i++)
            send_request(CMD_APPEND, 3'd4, 32'(i));
        send_request(CMD_APPEND, 3'd2, -32'sd3);
        send_merge();
    endtask

    task automatic test_full_store();
        load_and_merge(LIST_DEPTH, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_random_merges();
        int mode;
        while (items_sent < 300)
        begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 9);
            case (mode)
                0:
                begin
                    // stray request outside a well-formed sequence
                    if ($urandom_range(0, 1) == 0)
                        send_merge();
                    else
                        send_request(CMD_APPEND, 3'($urandom), $urandom);
                end
                1:       load_and_merge(4, 1'b0, 1'b0, 1'b0);
                2:       load_and_merge(4, 1'b0, 1'b1, 1'b1);
                3:       load_and_merge(LIST_DEPTH + 2, 1'b0, 1'b1, 1'b0);
                default: load_and_merge(4, 1'b0, 1'b1, 1'b0);
            endcase
        end
    endtask

    task automatic test_back_to_back();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        while (items_sent < 330)
            load_and_merge(3, 1'b0, 1'b1, $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        for (int l = 0; l < NUM_LISTS; l++)
            list_fill[l] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_merge();
        test_extreme_values();
        test_equal_heads();
        test_list_overflow();
        test_full_store();
        test_random_merges();
        test_back_to_back();

        s_tvalid <= 1'b0;
        while (merged_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
